// ----- src/tournament_branch_predictor_unit_defines.svh -----
// Assertion macros shared by the tournament branch predictor RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_UNIT_DEFINES_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TBP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tbp_pkg.sv -----
// Shared types, constants and counter helpers for the tournament branch predictor.
// No dependencies; used by tbp_tables and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

    // Two-bit saturating counter.
    typedef logic [1:0] ctr_t;

    localparam ctr_t CTR_MIN = 2'd0;
    localparam ctr_t CTR_MAX = 2'd3;

    // Reset values: predictors strongly taken, selector strongly gshare.
    localparam ctr_t PRED_RESET = CTR_MAX;
    localparam ctr_t SEL_RESET  = CTR_MIN;

    // Status of the write-back stage handed to the output register.
    typedef struct packed {
        logic valid;
        logic predicted_taken;
        logic prediction_correct;
        logic gshare_correct;
        logic bimodal_correct;
    } result_t;

    function automatic ctr_t ctr_inc(ctr_t c);
        ctr_t r;
        r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
        return r;
    endfunction

    function automatic ctr_t ctr_dec(ctr_t c);
        ctr_t r;
        r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
        return r;
    endfunction

    // Moves a counter one step toward the outcome.
    function automatic ctr_t ctr_train(ctr_t c, logic up);
        ctr_t r;
        r = up ? ctr_inc(c) : ctr_dec(c);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/tbp_modc.sv -----
// Two-stage remainder by a constant divisor, using a reciprocal multiply and one correction.
// Standalone; used twice by tbp_index.
`timescale 1ns / 1ps
`default_nettype none

module tbp_modc #(
    parameter int IN_W    = 32,
    parameter int DIVISOR = 2048,
    parameter int OUT_W   = $clog2(DIVISOR)
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [IN_W-1:0]  x,
    output logic      [OUT_W-1:0] r
);

    localparam int EW = IN_W + 1;
    localparam int LW = OUT_W + 1;
    localparam logic [EW-1:0] RECIP  = EW'((64'd1 << EW) / 64'(DIVISOR));
    localparam logic [LW-1:0] DIV_LW = LW'(DIVISOR);

    logic [EW-1:0]   xe;
    logic [2*EW-1:0] prod;
    logic [EW-1:0]   q_reg;
    logic [LW-1:0]   xlo_reg;
    logic [LW-1:0]   qd;
    logic [LW-1:0]   rem0;
    logic [LW-1:0]   rem1;
    logic [OUT_W-1:0] r_reg;

    assign xe   = {1'b0, x};
    assign prod = {{EW{1'b0}}, xe} * {{EW{1'b0}}, RECIP};

    // The quotient estimate is low by at most one, so the true remainder is
    // below twice the divisor and fits in the low LW bits.
    assign qd   = q_reg[LW-1:0] * DIV_LW;
    assign rem0 = xlo_reg - qd;
    assign rem1 = (rem0 >= DIV_LW) ? rem0 - DIV_LW : rem0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg   <= prod[2*EW-1:EW];
            xlo_reg <= xe[LW-1:0];
            r_reg   <= rem1[OUT_W-1:0];
        end
    end

    assign r = r_reg;

endmodule

`default_nettype wire

// ----- src/tbp_index.sv -----
// Index pipeline: bimodal index from the address, then gshare index from it and the history.
// Depends on tbp_modc.
`timescale 1ns / 1ps
`default_nettype none

module tbp_index #(
    parameter int TABLE_ENTRIES = 2048,
    parameter int HISTORY_BITS  = 11,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    adv,
    input  wire logic                    accept,
    input  wire logic [31:0]             branch_address,
    input  wire logic                    taken,
    input  wire logic [HISTORY_BITS-1:0] hist,
    output logic                         rd_valid,
    output logic                         rd_taken,
    output logic      [IDX_W-1:0]        rd_bidx,
    output logic      [IDX_W-1:0]        rd_gidx
);

    localparam int XW = (IDX_W > HISTORY_BITS) ? IDX_W : HISTORY_BITS;

    logic [3:0]              vld_reg;
    logic                    s1_taken_reg;
    logic [HISTORY_BITS-1:0] s1_hist_reg;
    logic                    s2_taken_reg;
    logic [HISTORY_BITS-1:0] s2_hist_reg;
    logic                    s3_taken_reg;
    logic [IDX_W-1:0]        s3_bidx_reg;
    logic                    s4_taken_reg;
    logic [IDX_W-1:0]        s4_bidx_reg;
    logic [IDX_W-1:0]        bidx;
    logic [IDX_W-1:0]        gidx;
    logic [XW-1:0]           gx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_taken_reg <= taken;
            s1_hist_reg  <= hist;
            s2_taken_reg <= s1_taken_reg;
            s2_hist_reg  <= s1_hist_reg;
            s3_taken_reg <= s2_taken_reg;
            s3_bidx_reg  <= bidx;
            s4_taken_reg <= s3_taken_reg;
            s4_bidx_reg  <= s3_bidx_reg;
        end
    end

    tbp_modc #(
        .IN_W    (32),
        .DIVISOR (TABLE_ENTRIES),
        .OUT_W   (IDX_W)
    ) u_bidx_mod (
        .clk (clk),
        .en  (adv),
        .x   (branch_address),
        .r   (bidx)
    );

    assign gx = XW'(bidx) ^ XW'(s2_hist_reg);

    tbp_modc #(
        .IN_W    (XW),
        .DIVISOR (TABLE_ENTRIES),
        .OUT_W   (IDX_W)
    ) u_gidx_mod (
        .clk (clk),
        .en  (adv),
        .x   (gx),
        .r   (gidx)
    );

    assign rd_valid = vld_reg[3];
    assign rd_taken = s4_taken_reg;
    assign rd_bidx  = s4_bidx_reg;
    assign rd_gidx  = gidx;

endmodule

`default_nettype wire

// ----- src/tbp_tables.sv -----
// Counter tables with clearing pass, read stage, write-back forwarding and training.
// Depends on tbp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "tournament_branch_predictor_unit_defines.svh"

module tbp_tables #(
    parameter int TABLE_ENTRIES = 2048,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic             rd_valid,
    input  wire logic             rd_taken,
    input  wire logic [IDX_W-1:0] rd_bidx,
    input  wire logic [IDX_W-1:0] rd_gidx,
    output logic                  clear_done,
    output tbp_pkg::result_t      result
);

    tbp_pkg::ctr_t gshare_mem  [TABLE_ENTRIES];
    tbp_pkg::ctr_t bimodal_mem [TABLE_ENTRIES];
    tbp_pkg::ctr_t chooser_mem [TABLE_ENTRIES];

    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_addr_reg;

    logic             w_valid_reg;
    logic             w_taken_reg;
    logic [IDX_W-1:0] w_bidx_reg;
    logic [IDX_W-1:0] w_gidx_reg;
    tbp_pkg::ctr_t    g_rd_reg;
    tbp_pkg::ctr_t    b_rd_reg;
    tbp_pkg::ctr_t    c_rd_reg;

    logic             fwd_valid_reg;
    logic [IDX_W-1:0] fwd_bidx_reg;
    logic [IDX_W-1:0] fwd_gidx_reg;
    tbp_pkg::ctr_t    fwd_g_reg;
    tbp_pkg::ctr_t    fwd_b_reg;
    tbp_pkg::ctr_t    fwd_c_reg;

    tbp_pkg::ctr_t    g_cur;
    tbp_pkg::ctr_t    b_cur;
    tbp_pkg::ctr_t    c_cur;
    tbp_pkg::ctr_t    g_new;
    tbp_pkg::ctr_t    b_new;
    tbp_pkg::ctr_t    c_new;
    logic             gpred;
    logic             bpred;
    logic             gok;
    logic             bok;
    logic             pred;
    logic             w_fire;

    logic             wr_en;
    logic [IDX_W-1:0] wr_gaddr;
    logic [IDX_W-1:0] wr_baddr;
    tbp_pkg::ctr_t    wr_g;
    tbp_pkg::ctr_t    wr_b;
    tbp_pkg::ctr_t    wr_c;

    // Clearing pass after reset, one entry of each table per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == IDX_W'(TABLE_ENTRIES - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            end
        end
    end

    assign clear_done = !clr_busy_reg;

    // An entry written by the previous item on the same edge as this item's
    // read came back stale from the memory, so it is taken from the bypass.
    assign g_cur = (fwd_valid_reg && fwd_gidx_reg == w_gidx_reg) ? fwd_g_reg : g_rd_reg;
    assign b_cur = (fwd_valid_reg && fwd_bidx_reg == w_bidx_reg) ? fwd_b_reg : b_rd_reg;
    assign c_cur = (fwd_valid_reg && fwd_bidx_reg == w_bidx_reg) ? fwd_c_reg : c_rd_reg;

    assign gpred = g_cur[1];
    assign bpred = b_cur[1];
    assign gok   = (gpred == w_taken_reg);
    assign bok   = (bpred == w_taken_reg);
    assign pred  = c_cur[1] ? bpred : gpred;

    assign g_new = tbp_pkg::ctr_train(g_cur, w_taken_reg);
    assign b_new = tbp_pkg::ctr_train(b_cur, w_taken_reg);

    always_comb
    begin
        priority if (gok && !bok)
        begin
            c_new = tbp_pkg::ctr_dec(c_cur);
        end
        else if (bok && !gok)
        begin
            c_new = tbp_pkg::ctr_inc(c_cur);
        end
        else
        begin
            c_new = c_cur;
        end
    end

    assign w_fire   = w_valid_reg && adv;
    assign wr_en    = clr_busy_reg || w_fire;
    assign wr_gaddr = clr_busy_reg ? clr_addr_reg : w_gidx_reg;
    assign wr_baddr = clr_busy_reg ? clr_addr_reg : w_bidx_reg;
    assign wr_g     = clr_busy_reg ? tbp_pkg::PRED_RESET : g_new;
    assign wr_b     = clr_busy_reg ? tbp_pkg::PRED_RESET : b_new;
    assign wr_c     = clr_busy_reg ? tbp_pkg::SEL_RESET : c_new;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gshare_mem[wr_gaddr] <= wr_g;
        end
        if (adv)
        begin
            g_rd_reg <= gshare_mem[rd_gidx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bimodal_mem[wr_baddr] <= wr_b;
        end
        if (adv)
        begin
            b_rd_reg <= bimodal_mem[rd_bidx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            chooser_mem[wr_baddr] <= wr_c;
        end
        if (adv)
        begin
            c_rd_reg <= chooser_mem[rd_bidx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            w_valid_reg   <= rd_valid;
            fwd_valid_reg <= w_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_taken_reg  <= rd_taken;
            w_bidx_reg   <= rd_bidx;
            w_gidx_reg   <= rd_gidx;
            fwd_bidx_reg <= w_bidx_reg;
            fwd_gidx_reg <= w_gidx_reg;
            fwd_g_reg    <= g_new;
            fwd_b_reg    <= b_new;
            fwd_c_reg    <= c_new;
        end
    end

    assign result.valid              = w_valid_reg;
    assign result.predicted_taken    = pred;
    assign result.prediction_correct = (pred == w_taken_reg);
    assign result.gshare_correct     = gok;
    assign result.bimodal_correct    = bok;

    `TBP_ASSERT_IMPLY(a_clear_pipe_empty, clr_busy_reg, !w_valid_reg, "item in write-back during clear")
    `TBP_ASSERT_NEXT(a_clear_stays_done, !clr_busy_reg, !clr_busy_reg, "clearing pass restarted")
    `TBP_ASSERT_NEXT(a_bypass_tracks_write, w_fire, fwd_valid_reg && fwd_gidx_reg == $past(w_gidx_reg), "bypass lost write")

endmodule

`default_nettype wire

// ----- src/tournament_branch_predictor_unit.sv -----
// Top level of the tournament branch predictor: handshake, history, output register, totals.
// Depends on tbp_pkg, tbp_index, tbp_tables and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "tournament_branch_predictor_unit_defines.svh"

// Tournament (gshare plus bimodal) branch predictor. Each input beat carries one
// resolved branch; each output beat gives the prediction chosen by the selector
// table, whether it and each of the two predictors were right, and the running
// totals of correct predictions and branches after this branch (both wrap at
// 2^32). After reset the block clears its three counter tables and holds
// in_ready low while it does so. From then on it takes one branch per cycle
// while not halted: the index pipeline (two constant-remainder units of two
// stages each), one table read stage and the write-back stage run in lock
// step. A read that meets the previous branch's table write on the same cycle
// is served from a bypass register, which is what allows back-to-back branches
// to the same entry. The whole pipeline halts only while a finished result is
// held in the output register and out_ready is low; during that time in_ready
// is low as well.
module tournament_branch_predictor_unit #(
    parameter int TABLE_ENTRIES = 2048,
    parameter int HISTORY_BITS  = 11
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] branch_address,
    input  wire logic        taken,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             predicted_taken,
    output logic             prediction_correct,
    output logic             gshare_correct,
    output logic             bimodal_correct,
    output logic      [31:0] correct_total,
    output logic      [31:0] branch_total
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic                    adv;
    logic                    accept;
    logic                    clear_done;
    logic [HISTORY_BITS-1:0] hist_reg;
    logic [HISTORY_BITS-1:0] hist_next;

    logic                    rd_valid;
    logic                    rd_taken;
    logic [IDX_W-1:0]        rd_bidx;
    logic [IDX_W-1:0]        rd_gidx;
    tbp_pkg::result_t        result;

    logic                    out_load;
    logic                    out_valid_reg;
    logic                    predicted_taken_reg;
    logic                    prediction_correct_reg;
    logic                    gshare_correct_reg;
    logic                    bimodal_correct_reg;
    logic [31:0]             correct_count_reg;
    logic [31:0]             branch_count_reg;

    // Every stage moves together unless the output register is full and
    // the consumer is not taking the beat.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv && clear_done;
    assign accept   = in_valid && in_ready;
    assign out_load = adv && result.valid;

    // The global history depends only on outcomes, so it is brought up to date
    // at acceptance; each branch carries the history that preceded it.
    assign hist_next = {hist_reg[HISTORY_BITS-2:0], taken};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (accept)
        begin
            hist_reg <= hist_next;
        end
    end

    tbp_index #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HISTORY_BITS  (HISTORY_BITS),
        .IDX_W         (IDX_W)
    ) u_index (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .accept         (accept),
        .branch_address (branch_address),
        .taken          (taken),
        .hist           (hist_reg),
        .rd_valid       (rd_valid),
        .rd_taken       (rd_taken),
        .rd_bidx        (rd_bidx),
        .rd_gidx        (rd_gidx)
    );

    tbp_tables #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_tables (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .rd_valid   (rd_valid),
        .rd_taken   (rd_taken),
        .rd_bidx    (rd_bidx),
        .rd_gidx    (rd_gidx),
        .clear_done (clear_done),
        .result     (result)
    );

    // The running totals change only when a new result is loaded, so they can
    // drive the total ports directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            correct_count_reg <= '0;
            branch_count_reg  <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= result.valid;
            if (result.valid)
            begin
                correct_count_reg <= correct_count_reg + 32'(result.prediction_correct);
                branch_count_reg  <= branch_count_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            predicted_taken_reg    <= result.predicted_taken;
            prediction_correct_reg <= result.prediction_correct;
            gshare_correct_reg     <= result.gshare_correct;
            bimodal_correct_reg    <= result.bimodal_correct;
        end
    end

    assign out_valid          = out_valid_reg;
    assign predicted_taken    = predicted_taken_reg;
    assign prediction_correct = prediction_correct_reg;
    assign gshare_correct     = gshare_correct_reg;
    assign bimodal_correct    = bimodal_correct_reg;
    assign correct_total      = correct_count_reg;
    assign branch_total       = branch_count_reg;

    `TBP_ASSERT_NEXT(a_branch_total_step, out_load, branch_total == $past(branch_total) + 32'd1, "branch total step")
    `TBP_ASSERT_NEXT(a_correct_total_step, out_load, correct_total == $past(correct_total) + 32'(prediction_correct), "correct total step")
    `TBP_ASSERT_IMPLY(a_choice_agrees, out_valid && (gshare_correct == bimodal_correct), prediction_correct == gshare_correct, "choice disagrees with both predictors")

endmodule

`default_nettype wire
